// ----- src/le_channel_select_csa2_unit_defines.svh -----
// Assertion macros shared by the channel selection block.
// Needs clk_i and rst_ni in the scope of each module that uses them.
`ifndef LE_CHANNEL_SELECT_CSA2_UNIT_DEFINES_SVH
`define LE_CHANNEL_SELECT_CSA2_UNIT_DEFINES_SVH

// Plain property, checked at every rising clock edge outside reset.
`define LECS2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication built on the macro above.
`define LECS2_ASSERT_IMP(lbl, ante, cons, msg) \
  `LECS2_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ----- src/lecs2_pkg.sv -----
// Constants, types and the hop round function of the channel selection block.
// No dependencies; every other file but the defines header refers to it by scoped names.
package lecs2_pkg;

  localparam int unsigned NUM_CHANNELS = 37;
  localparam int unsigned MAP_W        = 37;
  localparam int unsigned CHAN_W       = 6;
  localparam int unsigned USED_W       = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned NUM_GROUPS   = (NUM_CHANNELS + 7) / 8;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 37;
  localparam int unsigned AA_W         = 32;
  localparam int unsigned WORD_W       = 16;

  // Reciprocal for the remainder by NUM_CHANNELS of a 16-bit value.
  localparam int unsigned RECIP_SHIFT  = 22;
  localparam int unsigned RECIP_W      = 23;
  localparam int unsigned RECIP        = ((2 ** RECIP_SHIFT) + NUM_CHANNELS - 1) / NUM_CHANNELS;
  localparam int unsigned PROD_W       = WORD_W + RECIP_W;
  localparam int unsigned QUOT_W       = PROD_W - RECIP_SHIFT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCESS_ADDRESS = 1'b0,
    CFG_CHANNEL_MAP    = 1'b1
  } cfg_reg_e;

  typedef logic [USED_W-1:0] rank_t;

  typedef struct packed {
    logic [NUM_CHANNELS-1:0][USED_W-1:0] rank;
    logic [USED_W-1:0]                   used;
  } map_info_t;

  // One hop round: reverse the bits of each byte, then 17 * x + id mod 2^16.
  function automatic logic [WORD_W-1:0] hop_round(input logic [WORD_W-1:0] x,
                                                  input logic [WORD_W-1:0] id);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i]  = x[i];
      r[15 - i] = x[8 + i];
    end
    return r + {r[WORD_W-5:0], 4'b0000} + id;
  endfunction

endpackage

// ----- src/lecs2_if.sv -----
// Valid/ready channel interfaces for the channel selection block.
// Depends on lecs2_pkg for field widths.
interface lecs2_in_if;
  logic                          valid;
  logic                          ready;
  logic [lecs2_pkg::WORD_W-1:0]  event_counter;

  modport source (output valid, output event_counter, input ready);
  modport sink   (input valid, input event_counter, output ready);
endinterface

interface lecs2_out_if;
  logic                          valid;
  logic                          ready;
  logic [lecs2_pkg::CHAN_W-1:0]  channel;
  logic                          map_error;

  modport source (output valid, output channel, output map_error, input ready);
  modport sink   (input valid, input channel, input map_error, output ready);
endinterface

// ----- src/lecs2_map_prep.sv -----
// Derives the used-channel count and the rank of every channel from the map.
// Depends on lecs2_pkg; three register levels, refreshed every cycle.
module lecs2_map_prep (
  input  logic                                clk_i,
  input  logic [lecs2_pkg::NUM_CHANNELS-1:0]  used_map_i,
  output lecs2_pkg::map_info_t                info_o
);

  localparam int unsigned PAD_W = lecs2_pkg::NUM_GROUPS * 8;

  logic [PAD_W-1:0]                              pad;
  logic [PAD_W-1:0][2:0]                         pc_d, pc_q;
  logic [lecs2_pkg::NUM_GROUPS-1:0][3:0]         gc_d, gc_q;
  logic [lecs2_pkg::NUM_GROUPS-1:0][lecs2_pkg::USED_W-1:0] base_d, base_q;
  logic [lecs2_pkg::USED_W-1:0]                  used_d, used_q;
  lecs2_pkg::map_info_t                          info_d, info_q;

  assign pad = PAD_W'(used_map_i);

  // Level one: counts inside each byte-wide group.
  always_comb begin
    logic [3:0] cnt;
    for (int g = 0; g < lecs2_pkg::NUM_GROUPS; g++) begin
      cnt = '0;
      for (int b = 0; b < 8; b++) begin
        pc_d[g * 8 + b] = cnt[2:0];
        cnt = cnt + 4'(pad[g * 8 + b]);
      end
      gc_d[g] = cnt;
    end
  end

  // Level two: running group bases and the total.
  always_comb begin
    logic [lecs2_pkg::USED_W-1:0] acc;
    acc = '0;
    for (int g = 0; g < lecs2_pkg::NUM_GROUPS; g++) begin
      base_d[g] = acc;
      acc = acc + lecs2_pkg::USED_W'(gc_q[g]);
    end
    used_d = acc;
  end

  // Level three: rank of each channel among the used ones.
  always_comb begin
    for (int c = 0; c < lecs2_pkg::NUM_CHANNELS; c++) begin
      info_d.rank[c] = base_q[c >> 3] + lecs2_pkg::USED_W'(pc_q[c]);
    end
    info_d.used = used_q;
  end

  always_ff @(posedge clk_i) begin
    pc_q   <= pc_d;
    gc_q   <= gc_d;
    base_q <= base_d;
    used_q <= used_d;
    info_q <= info_d;
  end

  assign info_o = info_q;

endmodule

// ----- src/le_channel_select_csa2_unit.sv -----
// Top level of the LE channel selection algorithm #2 block.
// Depends on lecs2_pkg, lecs2_if.sv, lecs2_map_prep and the defines header.
//
//   Channel  Direction  Payload                      Handshake
//   req_i    in         event_counter[15:0]          valid/ready
//   rsp_o    out        channel[5:0], map_error      valid/ready
//   cfg      in         cfg_idx_i, cfg_wdata_i[36:0] cfg_we_i, no wait
//
// One item enters per cycle unless a stall at the output backs up to the input.
// Its result moves through the stages in order and waits in the output register.
// The six stages are three hop rounds, the reciprocal multiply, the remainder
// with the rank match, and the final selection.
// Reset clears the valid bits and loads the registers with access address 0
// and a full channel map. A stall at the output holds the full stages behind
// it, while empty stages keep filling, so no item is lost or repeated.
// Map-derived ranks trail a map write through the lecs2_map_prep registers, and
// are read first in stage four, so an item may follow a write in the next cycle.
`include "le_channel_select_csa2_unit_defines.svh"

module le_channel_select_csa2_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lecs2_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lecs2_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  lecs2_in_if.sink                            req_i,
  lecs2_out_if.source                         rsp_o
);

  localparam int unsigned NUM_STAGES = 6;
  localparam int unsigned EXT_W      = 2 ** lecs2_pkg::CHAN_W;
  localparam int unsigned W          = lecs2_pkg::WORD_W;
  localparam int unsigned SCALED_W   = lecs2_pkg::USED_W + W;

  // Configuration registers.
  logic [lecs2_pkg::AA_W-1:0]   access_address_q;
  logic [lecs2_pkg::MAP_W-1:0]  channel_map_q;
  logic [W-1:0]                 chan_id;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_address_q <= '0;
      channel_map_q    <= '1;
    end else if (cfg_we_i) begin
      unique case (lecs2_pkg::cfg_reg_e'(cfg_idx_i))
        lecs2_pkg::CFG_ACCESS_ADDRESS: begin
          access_address_q <= cfg_wdata_i[lecs2_pkg::AA_W-1:0];
        end
        lecs2_pkg::CFG_CHANNEL_MAP: begin
          channel_map_q <= cfg_wdata_i[lecs2_pkg::MAP_W-1:0];
        end
      endcase
    end
  end

  // The channel identifier folds the access address into 16 bits.
  assign chan_id = access_address_q[31:16] ^ access_address_q[15:0];

  // Channels past the end of the map count as unused.
  logic [lecs2_pkg::NUM_CHANNELS-1:0] used_map;
  logic [EXT_W-1:0]                   map_ext;

  for (genvar c = 0; c < lecs2_pkg::NUM_CHANNELS; c++) begin : g_used
    if (c < lecs2_pkg::MAP_W) begin : g_in
      assign used_map[c] = channel_map_q[c];
    end else begin : g_out
      assign used_map[c] = 1'b0;
    end
  end

  assign map_ext = EXT_W'(used_map);

  lecs2_pkg::map_info_t info;

  lecs2_map_prep u_map_prep (
    .clk_i      (clk_i),
    .used_map_i (used_map),
    .info_o     (info)
  );

  // Stall control: a stage may load when it is empty or the next one loads.
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES:0]   en;

  always_comb begin
    en[NUM_STAGES] = rsp_o.ready;
    for (int k = NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k + 1];
    end
  end

  assign req_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= req_i.valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k - 1];
        end
      end
    end
  end

  // Stages one to three: the three hop rounds, whitened by the identifier.
  logic [W-1:0] x1_q, x2_q, prn_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x1_q <= lecs2_pkg::hop_round(req_i.event_counter ^ chan_id, chan_id);
    end
    if (en[1]) begin
      x2_q <= lecs2_pkg::hop_round(x1_q, chan_id);
    end
    if (en[2]) begin
      prn_q <= lecs2_pkg::hop_round(x2_q, chan_id) ^ chan_id;
    end
  end

  // Stage four: reciprocal product for the remainder, and the remap index.
  logic [lecs2_pkg::PROD_W-1:0]     prod_q;
  logic [W-1:0]                     prn4_q;
  logic [lecs2_pkg::USED_W-1:0]     idx_q;
  logic [SCALED_W-1:0]              scaled;

  assign scaled = SCALED_W'(info.used) * SCALED_W'(prn_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      prod_q <= lecs2_pkg::PROD_W'(prn_q) * lecs2_pkg::PROD_W'(lecs2_pkg::RECIP);
      prn4_q <= prn_q;
      idx_q  <= scaled[SCALED_W-1:W];
    end
  end

  // Stage five: the unmapped channel and the channel whose rank is the index.
  logic [lecs2_pkg::QUOT_W-1:0]       quot;
  logic [W-1:0]                       rem_raw;
  logic [W-1:0]                       rem_fix;
  logic [lecs2_pkg::CHAN_W-1:0]       unmapped_q;
  logic [lecs2_pkg::NUM_CHANNELS-1:0] hit_d, hit_q;

  assign quot    = prod_q[lecs2_pkg::PROD_W-1:lecs2_pkg::RECIP_SHIFT];
  assign rem_raw = prn4_q - W'(quot * W'(lecs2_pkg::NUM_CHANNELS));
  assign rem_fix = (rem_raw >= W'(lecs2_pkg::NUM_CHANNELS))
                   ? rem_raw - W'(lecs2_pkg::NUM_CHANNELS) : rem_raw;

  always_comb begin
    for (int c = 0; c < lecs2_pkg::NUM_CHANNELS; c++) begin
      hit_d[c] = used_map[c] && (info.rank[c] == idx_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      unmapped_q <= rem_fix[lecs2_pkg::CHAN_W-1:0];
      hit_q      <= hit_d;
    end
  end

  // Stage six: keep the unmapped channel if used, else remap, or flag an empty map.
  logic [lecs2_pkg::CHAN_W-1:0] remap_chan;
  logic [lecs2_pkg::CHAN_W-1:0] chan_d, chan_q;
  logic                         err_d, err_q;
  logic                         out_valid;

  always_comb begin
    remap_chan = '0;
    for (int c = 0; c < lecs2_pkg::NUM_CHANNELS; c++) begin
      if (hit_q[c]) begin
        remap_chan = remap_chan | lecs2_pkg::CHAN_W'(c);
      end
    end
  end

  always_comb begin
    err_d = 1'b0;
    priority if (map_ext[unmapped_q]) begin
      chan_d = unmapped_q;
    end else if (info.used == '0) begin
      chan_d = '0;
      err_d  = 1'b1;
    end else begin
      chan_d = remap_chan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      chan_q <= chan_d;
      err_q  <= err_d;
    end
  end

  assign out_valid       = valid_q[NUM_STAGES-1];
  assign rsp_o.valid     = out_valid;
  assign rsp_o.channel   = chan_q;
  assign rsp_o.map_error = err_q;

  // An error result always carries channel zero.
  `LECS2_ASSERT_IMP(a_err_chan_zero, out_valid && err_q, chan_q == '0, "error with a channel")
  // Every good result names a channel that the map marks as used.
  `LECS2_ASSERT_IMP(a_chan_used, out_valid && !err_q, map_ext[chan_q], "channel not in map")
  // Ranks are distinct, so at most one channel matches the remap index.
  `LECS2_ASSERT_IMP(a_hit_onehot, valid_q[4], $onehot0(hit_q), "several remap hits")
  // The error flag is raised exactly when the map is empty.
  `LECS2_ASSERT_IMP(a_err_iff_empty, out_valid, err_q == (info.used == '0), "bad error flag")

endmodule
